FILE: hw/rtl/rtcf_pkg.sv
`default_nettype none
package rtcf_pkg;

  // Decoded snapshot after BCD, 12-hour and century handling
  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [11:0] year;
  } rtcf_time_t;

  localparam logic [7:0]  StatBinary  = 8'h04;
  localparam logic [7:0]  Stat24Hour  = 8'h02;
  localparam logic [7:0]  HourPmFlag  = 8'h80;
  localparam logic [7:0]  HourMask    = 8'h7F;

  localparam logic [11:0] YearBase2000 = 12'd2000;
  localparam logic [11:0] EraBase5     = 12'd2000;
  localparam logic [11:0] EraBase4     = 12'd1600;

  // era*146097 - 719468 for the two eras the year range can reach
  localparam logic signed [18:0] DayOffEra4 = -19'sd135080;
  localparam logic signed [18:0] DayOffEra5 = 19'sd11017;

  localparam logic [15:0] MonthMul    = 16'd153;
  localparam logic [15:0] Recip5      = 16'd52429;  // ceil(2^18 / 5)
  localparam int          Recip5Shift = 18;
  localparam logic [17:0] DaysPerYear = 18'd365;
  localparam logic signed [17:0] SecPerDay = 18'sd86400;

  // Low nibble plus ten times high nibble; nibbles above 9 weigh as they are
  function automatic logic [7:0] bcd_decode(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'b0000, v[7:4]};
    return {4'b0000, v[3:0]} + (hi << 3) + (hi << 1);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rtcf_in_if.sv
`default_nettype none
interface rtcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sec_raw;
  logic [7:0] min_raw;
  logic [7:0] hour_raw;
  logic [7:0] day_raw;
  logic [7:0] month_raw;
  logic [7:0] year_raw;
  logic [7:0] century_raw;
  logic [7:0] status_raw;

  modport source (
    output valid, sec_raw, min_raw, hour_raw, day_raw, month_raw, year_raw,
           century_raw, status_raw,
    input  ready
  );
  modport sink (
    input  valid, sec_raw, min_raw, hour_raw, day_raw, month_raw, year_raw,
           century_raw, status_raw,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/rtcf_out_if.sv
`default_nettype none
interface rtcf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rtcf_decode.sv
`default_nettype none
module rtcf_decode import rtcf_pkg::*; (
  input  logic [7:0] sec_raw,
  input  logic [7:0] min_raw,
  input  logic [7:0] hour_raw,
  input  logic [7:0] day_raw,
  input  logic [7:0] month_raw,
  input  logic [7:0] year_raw,
  input  logic [7:0] century_raw,
  input  logic [7:0] status_raw,
  output rtcf_time_t tm
);

  logic       bcd_mode;
  logic       twelve;
  logic       pm;
  logic [7:0] hour_m;
  logic [7:0] s_d, mi_d, h_d, d_d, mo_d, y_d, c_d;
  logic [7:0] h_adj;

  assign bcd_mode = (status_raw & StatBinary) == 8'h00;
  assign twelve   = (status_raw & Stat24Hour) == 8'h00;
  assign pm       = twelve && ((hour_raw & HourPmFlag) != 8'h00);
  assign hour_m   = hour_raw & HourMask;

  assign s_d  = bcd_mode ? bcd_decode(sec_raw)     : sec_raw;
  assign mi_d = bcd_mode ? bcd_decode(min_raw)     : min_raw;
  assign h_d  = bcd_mode ? bcd_decode(hour_m)      : hour_m;
  assign d_d  = bcd_mode ? bcd_decode(day_raw)     : day_raw;
  assign mo_d = bcd_mode ? bcd_decode(month_raw)   : month_raw;
  assign y_d  = bcd_mode ? bcd_decode(year_raw)    : year_raw;
  assign c_d  = bcd_mode ? bcd_decode(century_raw) : century_raw;

  always_comb begin
    h_adj = h_d;
    if (twelve) begin
      if (pm && h_d < 8'd12) begin
        h_adj = h_d + 8'd12;
      end else if (!pm && h_d == 8'd12) begin
        h_adj = 8'd0;
      end
    end
  end

  always_comb begin
    tm.sec   = s_d;
    tm.min   = mi_d;
    tm.hour  = h_adj;
    tm.day   = (d_d == 8'd0) ? 8'd1 : d_d;
    tm.month = (mo_d == 8'd0) ? 8'd1 : mo_d;
    case (c_d)
      8'd19:   tm.year = 12'd1900 + {4'b0000, y_d};
      8'd20:   tm.year = 12'd2000 + {4'b0000, y_d};
      8'd21:   tm.year = 12'd2100 + {4'b0000, y_d};
      default: tm.year = YearBase2000 + {4'b0000, y_d};
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_fields_to_epoch_seconds_unit.sv
`default_nettype none
// RTC byte snapshot to 32-bit epoch seconds, six register stages.
// Throughput: one item per cycle while epoch.ready holds; each stage refills as soon as it drains,
// so bubbles close up and a stalled output still lets upstream stages fill.
// Reset (rst, synchronous) clears the stage valid bits; data regs are not reset.
module rtc_fields_to_epoch_seconds_unit import rtcf_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  rtcf_in_if.sink    fields,
  rtcf_out_if.source epoch
);

  // Stage map:
  //  1: BCD / 12-hour / century decode, zero day/month fixup
  //  2: March-based year and month, 153*mp+2
  //  3: divide by 5 via reciprocal multiply, year-of-era day count
  //  4: signed day number from 1970, hh:mm:ss in seconds
  //  5: days * 86400 (low 32 bits)
  //  6: final add into output register

  logic [6:1] vld;
  logic [6:1] en;

  // Each stage loads when empty or when its item moves on
  assign en[6] = !vld[6] || epoch.ready;
  assign en[5] = !vld[5] || en[6];
  assign en[4] = !vld[4] || en[5];
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];

  assign fields.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= fields.valid;
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
      if (en[6]) vld[6] <= vld[5];
    end
  end

  // ---------------- stage 1: field decode ----------------
  rtcf_time_t tm_dec;
  rtcf_time_t s1_tm;

  rtcf_decode u_decode (
    .sec_raw     (fields.sec_raw),
    .min_raw     (fields.min_raw),
    .hour_raw    (fields.hour_raw),
    .day_raw     (fields.day_raw),
    .month_raw   (fields.month_raw),
    .year_raw    (fields.year_raw),
    .century_raw (fields.century_raw),
    .status_raw  (fields.status_raw),
    .tm          (tm_dec)
  );

  always_ff @(posedge clk) begin
    if (en[1]) s1_tm <= tm_dec;
  end

  // ---------------- stage 2: shifted year/month ----------------
  // Year starts in March, so Jan/Feb belong to the previous year.
  // Year range 1899..2355 spans only eras 4 and 5.
  logic [11:0] yy;
  logic        era5_c;
  logic [11:0] yoe_w;
  logic [7:0]  mp;
  logic [15:0] q_c;

  logic [7:0]  s2_sec, s2_min, s2_hour, s2_day;
  logic        s2_era5;
  logic [8:0]  s2_yoe;
  logic [15:0] s2_q;

  always_comb begin
    yy     = (s1_tm.month <= 8'd2) ? s1_tm.year - 12'd1 : s1_tm.year;
    era5_c = yy >= EraBase5;
    yoe_w  = yy - (era5_c ? EraBase5 : EraBase4);
    mp     = (s1_tm.month > 8'd2) ? s1_tm.month - 8'd3 : s1_tm.month + 8'd9;
    q_c    = {8'b0, mp} * MonthMul + 16'd2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sec  <= s1_tm.sec;
      s2_min  <= s1_tm.min;
      s2_hour <= s1_tm.hour;
      s2_day  <= s1_tm.day;
      s2_era5 <= era5_c;
      s2_yoe  <= yoe_w[8:0];
      s2_q    <= q_c;
    end
  end

  // ---------------- stage 3: day-of-year, day-of-era ----------------
  // q < 2^16, where the 18-bit reciprocal of 5 is exact
  // day-of-era reaches 146096, so it needs 18 bits
  logic [31:0] q_prod;
  logic [17:0] yoe_days;
  logic [1:0]  cent_cnt;

  logic [7:0]  s3_sec, s3_min, s3_hour, s3_day;
  logic        s3_era5;
  logic [12:0] s3_doy_base;
  logic [17:0] s3_yoe_days;

  always_comb begin
    q_prod   = {16'b0, s2_q} * {16'b0, Recip5};
    cent_cnt = {1'b0, s2_yoe >= 9'd100} + {1'b0, s2_yoe >= 9'd200}
             + {1'b0, s2_yoe >= 9'd300};
    yoe_days = {9'b0, s2_yoe} * DaysPerYear + {11'b0, s2_yoe[8:2]}
             - {16'b0, cent_cnt};
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sec      <= s2_sec;
      s3_min      <= s2_min;
      s3_hour     <= s2_hour;
      s3_day      <= s2_day;
      s3_era5     <= s2_era5;
      s3_doy_base <= q_prod[Recip5Shift+12:Recip5Shift];
      s3_yoe_days <= yoe_days;
    end
  end

  // ---------------- stage 4: day number and time of day ----------------
  logic signed [18:0] days_c;
  logic [18:0]        tod_c;

  logic signed [18:0] s4_days;
  logic [18:0]        s4_tod;

  always_comb begin
    days_c = (s3_era5 ? DayOffEra5 : DayOffEra4)
           + $signed({1'b0, s3_yoe_days})
           + $signed({6'b0, s3_doy_base})
           + $signed({11'b0, s3_day})
           - 19'sd1;
    tod_c  = {11'b0, s3_hour} * 19'd3600 + {11'b0, s3_min} * 19'd60
           + {11'b0, s3_sec};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_days <= days_c;
      s4_tod  <= tod_c;
    end
  end

  // ---------------- stage 5: days to seconds ----------------
  logic signed [36:0] day_sec;
  logic [31:0]        s5_day_sec;
  logic [18:0]        s5_tod;

  assign day_sec = s4_days * SecPerDay;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_day_sec <= day_sec[31:0];
      s5_tod     <= s4_tod;
    end
  end

  // ---------------- stage 6: output register ----------------
  logic [31:0] total;

  always_ff @(posedge clk) begin
    if (en[6]) total <= s5_day_sec + {13'b0, s5_tod};
  end

  assign epoch.valid         = vld[6];
  assign epoch.epoch_seconds = total;

endmodule
`default_nettype wire
